// ===== rtl/core/twodc_pkg.sv =====
// ----------------------------------------------------------------------------
// twodc_pkg: shared types, constants and helpers
// Request codes, word layout and the digit / light conversion functions
// used by the two-digit counter display.
// ----------------------------------------------------------------------------
package twodc_pkg;

  // field widths
  localparam int ReqW    = 3;
  localparam int SampleW = 16;
  localparam int CountW  = 7;
  localparam int SegW    = 7;
  localparam int WidthW  = 6;
  localparam int DigitW  = 4;

  // request codes
  localparam logic [ReqW-1:0] REQ_MUX   = 3'd0;
  localparam logic [ReqW-1:0] REQ_LIGHT = 3'd1;
  localparam logic [ReqW-1:0] REQ_DOWN  = 3'd2;
  localparam logic [ReqW-1:0] REQ_CMPL  = 3'd3;
  localparam logic [ReqW-1:0] REQ_UP    = 3'd4;

  // counter and brightness constants
  localparam logic [CountW-1:0] TopLimit  = 7'd99;
  localparam int                LightDiv  = 655;
  localparam int                LevelDiv  = 10;
  localparam int                LevelStep = LightDiv * LevelDiv;
  localparam int                NumLevels = 65535 / LevelStep;

  // stream word widths
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  // one accepted input word
  typedef struct packed {
    logic [ReqW-1:0]    req;
    logic [SampleW-1:0] sample;
    logic               pin_high;
  } item_t;

  // tens digit of a value below 100
  function automatic logic [DigitW-1:0] digit_tens(input logic [CountW-1:0] v);
    logic [DigitW-1:0] t;
    t = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= CountW'(k * 10)) t = DigitW'(k);
    end
    return t;
  endfunction

  // units digit of a value below 100
  function automatic logic [DigitW-1:0] digit_units(input logic [CountW-1:0] v);
    logic [DigitW-1:0] t;
    logic [CountW-1:0] tens10;
    t      = digit_tens(v);
    tens10 = CountW'({t, 3'b000}) + CountW'({t, 1'b0});
    return DigitW'(v - tens10);
  endfunction

  // segment pattern, bit 0 is segment a, active high
  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = '0;
    endcase
    return p;
  endfunction

  // brightness width from a light reading: level * 4 + 1
  function automatic logic [WidthW-1:0] light_width(input logic [SampleW-1:0] s);
    logic [DigitW-1:0] lvl;
    lvl = '0;
    for (int k = 1; k <= NumLevels; k++) begin
      if ({1'b0, s} >= 17'(k * LevelStep)) lvl = DigitW'(k);
    end
    return {lvl, 2'b01};
  endfunction

endpackage

// ===== rtl/core/twodc_in_reg.sv =====
// ----------------------------------------------------------------------------
// twodc_in_reg: input register stage
// Captures one input word per cycle while its slot is free or draining, and
// holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module twodc_in_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [twodc_pkg::ReqW-1:0]  in_tuser,
  input  logic [twodc_pkg::InDataW-1:0] in_tdata,
  input  logic                        adv,
  output logic                        vld,
  output twodc_pkg::item_t            item
);
  import twodc_pkg::*;

  logic  vld_r;
  item_t item_r;

  // free slot or slot drains this cycle
  assign in_tready = !vld_r || adv;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req      <= in_tuser;
      item_r.sample   <= in_tdata[SampleW-1:0];
      item_r.pin_high <= in_tdata[SampleW];
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// ===== rtl/core/twodc_update.sv =====
// ----------------------------------------------------------------------------
// twodc_update: counter / display update and result register
// Applies one event to the count, brightness and display latches and
// registers the resulting word for the output channel.
// ----------------------------------------------------------------------------
module twodc_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [twodc_pkg::CountW-1:0]  count_top,
  input  logic                          vld,
  input  twodc_pkg::item_t              item,
  output logic                          adv,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [twodc_pkg::OutDataW-1:0] out_tdata
);
  import twodc_pkg::*;

  logic [CountW-1:0] count_r, count_nxt;
  logic              phase_r, phase_nxt;
  logic [WidthW-1:0] bright_r, bright_nxt;
  logic [SegW-1:0]   seg_r, seg_nxt;
  logic [WidthW-1:0] tens_w_r, tens_w_nxt;
  logic [WidthW-1:0] units_w_r, units_w_nxt;
  logic              out_vld_r;
  logic [CountW-1:0] top;

  // result slot free or being taken
  assign adv = vld && (!out_vld_r || out_tready);

  // top above the limit acts as the limit
  assign top = (count_top > TopLimit) ? TopLimit : count_top;

  // event decode
  always_comb begin
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    bright_nxt  = bright_r;
    seg_nxt     = seg_r;
    tens_w_nxt  = tens_w_r;
    units_w_nxt = units_w_r;
    unique case (item.req)
      REQ_MUX: begin
        phase_nxt = !phase_r;
        if (!phase_r) begin
          seg_nxt     = seg_pattern(digit_units(count_r));
          tens_w_nxt  = '0;
          units_w_nxt = bright_r;
        end else begin
          seg_nxt     = seg_pattern(digit_tens(count_r));
          units_w_nxt = '0;
          tens_w_nxt  = bright_r;
        end
      end
      REQ_LIGHT: begin
        bright_nxt = light_width(item.sample);
      end
      REQ_DOWN: begin
        if (item.pin_high) begin
          if (count_r == '0 || count_r > top) count_nxt = top;
          else count_nxt = count_r - 1'b1;
        end
      end
      REQ_CMPL: begin
        if (item.pin_high) count_nxt = (count_r <= top) ? top - count_r : '0;
      end
      REQ_UP: begin
        if (item.pin_high) count_nxt = (count_r >= top) ? '0 : count_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      phase_r   <= 1'b0;
      bright_r  <= WidthW'(1);
      seg_r     <= '0;
      tens_w_r  <= WidthW'(1);
      units_w_r <= '0;
    end else if (adv) begin
      count_r   <= count_nxt;
      phase_r   <= phase_nxt;
      bright_r  <= bright_nxt;
      seg_r     <= seg_nxt;
      tens_w_r  <= tens_w_nxt;
      units_w_r <= units_w_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= vld;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {(OutDataW - CountW - 2 * WidthW - SegW)'(0),
                    count_nxt, units_w_nxt, tens_w_nxt, seg_nxt};
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== rtl/core/two_digit_button_counter_display_top.sv =====
// ----------------------------------------------------------------------------
// two_digit_button_counter_display_top: two-digit counter display
// Count 0..top with button events and multiplexed seven-segment output.
// ----------------------------------------------------------------------------
// Takes one event word per clock and returns one result word per event
// through the input register, then the update stage that writes the
// result register. Sustained rate is one word per cycle; it is set by
// the single update stage, which reads and writes the count and display
// latches in the same cycle. Backpressure on the output stalls the input
// only when both registers hold words. count_top is written through
// cfg_we / cfg_wdata while no word is in flight; the user must ensure this.
module two_digit_button_counter_display_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // config: count_top
  input  logic                          cfg_we,
  input  logic [twodc_pkg::CountW-1:0]  cfg_wdata,
  // input events
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [twodc_pkg::ReqW-1:0]    in_tuser,   // [2:0] req_type
  input  logic [twodc_pkg::InDataW-1:0] in_tdata,   // [15:0] light_sample, [16] pin_high
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [twodc_pkg::OutDataW-1:0] out_tdata  // [6:0] segments, [12:7] left_width,
                                                    // [18:13] right_width,
                                                    // [25:19] count_value
);
  import twodc_pkg::*;

  logic [CountW-1:0] top_r;
  logic              vld;
  logic              adv;
  item_t             item;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TopLimit;
    end else if (cfg_we) begin
      top_r <= cfg_wdata;
    end
  end

  twodc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .vld       (vld),
    .item      (item)
  );

  twodc_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_top  (top_r),
    .vld        (vld),
    .item       (item),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/core/twodc_checker.sv =====
// ----------------------------------------------------------------------------
// twodc_checker: port-level checks for the counter display
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module twodc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [twodc_pkg::CountW-1:0]  cfg_wdata,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [twodc_pkg::ReqW-1:0]    in_tuser,
  input logic [twodc_pkg::InDataW-1:0] in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [twodc_pkg::OutDataW-1:0] out_tdata
);
  import twodc_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // count never passes the limit
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:19] <= TopLimit)
    else $error("count above limit");

  // at most one digit enabled at a time
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:7] == '0 || out_tdata[18:13] == '0))
    else $error("both digits enabled");

endmodule

bind two_digit_button_counter_display_top twodc_checker u_twodc_checker (.*);
